>>> sv/assert_macros.svh
// Assertion macros for the detector RTL, included by the sequencer (betd_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define BETD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("betd assertion failed");
// Checked during reset as well.
`define BETD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("betd reset assertion failed");
`else
`define BETD_ASSERT(lbl, prop)
`define BETD_ASSERT_RST(lbl, prop)
`endif
`endif

>>> sv/betd_pkg.sv
// Types, constants and control structs of the block energy transient detector.
`default_nettype none
package betd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int BLOCK_MAX   = 64;

  localparam int CNT_W   = $clog2(BLOCK_MAX + 1);
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W   = 2 * SAMPLE_BITS - 1 + $clog2(BLOCK_MAX);
  localparam int MEAN_W  = 31;
  localparam int DIV_STEPS = SUM_W;
  localparam int ITER_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int SENS_W     = 9;
  localparam int COOL_W     = 16;

  localparam int THR_SQ_W = 2 * THR_W;
  localparam int RQ_W     = 11;
  localparam int RSQ_W    = 2 * RQ_W - 1;
  localparam int PROD_W   = RSQ_W + MEAN_W;
  localparam int MEAN_SH  = 16;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd3277;
  localparam logic [SENS_W-1:0] SENS_RESET = 9'd128;
  localparam logic [COOL_W-1:0] COOL_RESET = 16'd4410;
  localparam logic [SENS_W-1:0] SENS_ONE   = 9'd256;
  localparam logic [RQ_W-1:0]   R_BASE     = 11'd1152;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SENS      = 2'd1,
    CFG_COOLDOWN  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_block;
  } in_t;

  typedef struct packed {
    logic              transient;
    logic [MEAN_W-1:0] block_mean_square;
    logic              cooling_down;
  } out_t;

  typedef struct packed {
    logic capture;
    logic add;
    logic div_step;
    logic mul1;
    logic mul2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic blk_end;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/betd_ctrl.sv
// Sequencer: sample capture, accumulate, divide steps, multiplies and result write.
`default_nettype none
`include "assert_macros.svh"
module betd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output betd_pkg::cmd_t    cmd,
  input  betd_pkg::sts_t    sts
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADD  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [betd_pkg::ITER_W-1:0] LAST_ITER =
    betd_pkg::ITER_W'(betd_pkg::DIV_STEPS - 1);

  state_t                         state_r, state_nxt;
  logic [betd_pkg::ITER_W-1:0]    iter_r, iter_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        iter_nxt  = '0;
        state_nxt = sts.blk_end ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 1'b1;
        if (iter_r == LAST_ITER) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  `BETD_ASSERT(a_div_exit, (state_r == ST_DIV) && (iter_r == LAST_ITER) |=> (state_r == ST_MUL1))
  `BETD_ASSERT(a_iter_range, (state_r == ST_DIV) |-> (iter_r <= LAST_ITER))
  `BETD_ASSERT(a_finish_free, cmd.finish |-> !sts.out_full)
  `BETD_ASSERT(a_capture_add, cmd.capture |=> (state_r == ST_ADD))
  `BETD_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE))

endmodule
`default_nettype wire

>>> sv/betd_dp.sv
// Datapath: config registers, square accumulator, restoring divider, ratio test, output.
`default_nettype none
module betd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [betd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [betd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  betd_pkg::in_t                      in_data,
  output betd_pkg::out_t                     out_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  betd_pkg::cmd_t                     cmd,
  output betd_pkg::sts_t                     sts
);

  localparam int CNT_W  = betd_pkg::CNT_W;
  localparam int SUM_W  = betd_pkg::SUM_W;
  localparam int MEAN_W = betd_pkg::MEAN_W;
  localparam int COOL_W = betd_pkg::COOL_W;
  localparam int PROD_W = betd_pkg::PROD_W;
  localparam int RQ_W   = betd_pkg::RQ_W;
  localparam int RSQ_W  = betd_pkg::RSQ_W;
  localparam int THR_SQ_W = betd_pkg::THR_SQ_W;

  // configuration
  logic [betd_pkg::THR_W-1:0]  thr_r;
  logic [betd_pkg::SENS_W-1:0] sens_r;
  logic [COOL_W-1:0]           cool_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= betd_pkg::THR_RESET;
      sens_r     <= betd_pkg::SENS_RESET;
      cool_cfg_r <= betd_pkg::COOL_RESET;
    end else if (cfg_we) begin
      unique case (betd_pkg::cfg_idx_t'(cfg_index))
        betd_pkg::CFG_THRESHOLD: thr_r      <= cfg_wdata[betd_pkg::THR_W-1:0];
        betd_pkg::CFG_SENS:      sens_r     <= cfg_wdata[betd_pkg::SENS_W-1:0];
        betd_pkg::CFG_COOLDOWN:  cool_cfg_r <= cfg_wdata[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // squaring on capture, accumulation in the following cycle
  logic signed [2*betd_pkg::SAMPLE_BITS-1:0] sq_full;
  logic [betd_pkg::SQ_W-1:0] sq_r;
  logic                      last_r;
  logic [SUM_W-1:0]          sum_r, sum_add;
  logic [CNT_W-1:0]          cnt_r, cnt_inc;
  logic                      blk_end;

  assign sq_full = in_data.sample * in_data.sample;
  assign sum_add = sum_r + SUM_W'(sq_r);
  assign cnt_inc = cnt_r + CNT_W'(1);
  // a full block ends even without the mark
  assign blk_end = last_r || (cnt_inc >= CNT_W'(betd_pkg::BLOCK_MAX));

  // restoring divider, one quotient bit per beat of div_step
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt, dcnt_r;
  logic [CNT_W:0]   rem_sh, rem_sub;
  logic             div_ge;
  logic [MEAN_W-1:0] mean;

  assign rem_sh  = {rem_r, q_r[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dcnt_r};
  assign rem_sub = rem_sh - {1'b0, dcnt_r};
  assign rem_nxt = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign q_nxt   = {q_r[SUM_W-2:0], div_ge};
  assign mean    = q_r[MEAN_W-1:0];

  // ratio and threshold terms
  logic [betd_pkg::SENS_W-1:0] sens_sat;
  logic [RQ_W-1:0]             r_q8;
  logic [THR_SQ_W-1:0]         thr_sq_r, thr_sq_nxt;
  logic [RSQ_W-1:0]            r_sq_r, r_sq_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic [MEAN_W-1:0]           prev_r, floor_prev;

  assign sens_sat   = (sens_r > betd_pkg::SENS_ONE) ? betd_pkg::SENS_ONE : sens_r;
  assign r_q8       = betd_pkg::R_BASE - (RQ_W'({sens_sat, 1'b0}) + RQ_W'(sens_sat));
  assign thr_sq_nxt = THR_SQ_W'(thr_r) * THR_SQ_W'(thr_r);
  assign r_sq_nxt   = RSQ_W'(r_q8) * RSQ_W'(r_q8);
  assign floor_prev = (prev_r > MEAN_W'(1)) ? prev_r : MEAN_W'(1);
  assign prod_nxt   = PROD_W'(r_sq_r) * PROD_W'(floor_prev);

  // block-end decision
  logic [COOL_W-1:0] cool_r, cool_nxt;
  logic              cooling, hit;
  betd_pkg::out_t    out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign cooling = (cool_r != '0);
  assign hit = !cooling && (THR_SQ_W'(mean) > thr_sq_r)
               && (PROD_W'({mean, {betd_pkg::MEAN_SH{1'b0}}}) > prod_r);

  always_comb begin
    if (cooling) begin
      cool_nxt = (cool_r > COOL_W'(dcnt_r)) ? cool_r - COOL_W'(dcnt_r) : '0;
    end else if (hit) begin
      cool_nxt = cool_cfg_r;
    end else begin
      cool_nxt = cool_r;
    end
  end

  always_comb begin
    out_nxt.transient         = hit;
    out_nxt.block_mean_square = mean;
    out_nxt.cooling_down      = cooling;
  end

  always_comb begin
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_r   <= sq_full[betd_pkg::SQ_W-1:0];
      last_r <= in_data.last_in_block;
    end
    if (cmd.add && blk_end) begin
      q_r    <= sum_add;
      rem_r  <= '0;
      dcnt_r <= cnt_inc;
    end
    if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.mul1) begin
      thr_sq_r <= thr_sq_nxt;
      r_sq_r   <= r_sq_nxt;
    end
    if (cmd.mul2) prod_r <= prod_nxt;
    if (cmd.finish) out_r <= out_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      prev_r      <= '0;
      cool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add) begin
        sum_r <= blk_end ? '0 : sum_add;
        cnt_r <= blk_end ? '0 : cnt_inc;
      end
      if (cmd.finish) begin
        prev_r <= mean;
        cool_r <= cool_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_data     = out_r;
  assign out_valid    = out_valid_r;
  assign sts.blk_end  = blk_end;
  assign sts.out_full = out_valid_r && !out_ready;

endmodule
`default_nettype wire

>>> sv/block_energy_transient_detector_unit.sv
// A sample that does not end a block goes through capture and accumulate.
// A block-end sample goes through accumulate, 37 divider steps (one quotient
// bit each), two multiply steps and the decision; the result sits in an output register.
// The next sample is taken as soon as the decision is written, even if the result waits.
// Reset (rst_n low, synchronous) clears the accumulator, energy, cooldown and output
// valid, and loads the configuration defaults.
`default_nettype none
module block_energy_transient_detector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [betd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [betd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  betd_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output betd_pkg::out_t                   out_data
);

  betd_pkg::cmd_t cmd;
  betd_pkg::sts_t sts;

  betd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  betd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

>>> tb/block_energy_transient_detector_unit_tb.sv
// Testbench for the block energy transient detector: directed and random blocks, scoreboarded.
module block_energy_transient_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_PRINTS   = 40;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [betd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [betd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  betd_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  betd_pkg::out_t                  out_data;

  block_energy_transient_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of detector state and registers
  longint thr_lvl, sens_q8, cool_len;
  longint acc_sq, acc_n, last_ms, quiet_left;

  betd_pkg::out_t pending_blocks[$];
  betd_pkg::out_t want;
  int     err_count  = 0;
  int     beats_sent = 0;
  int     idle_pct   = 0;
  bit     hold_req   = 1'b0;

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Squared-domain energy tracking; queues one result per block end
  task automatic track_energy(input betd_pkg::in_t item);
    longint s, mag, mean, sens, r_q8, floor_ms;
    logic   hit, cooling;
    betd_pkg::out_t res;
    s = $signed(item.sample);
    mag = (s < 0) ? -s : s;
    acc_sq += mag * mag;
    acc_n++;
    if (!(item.last_in_block || acc_n >= betd_pkg::BLOCK_MAX)) return;
    mean = acc_sq / acc_n;
    hit = 1'b0;
    cooling = 1'b0;
    if (quiet_left > 0) begin
      cooling = 1'b1;
      quiet_left = (quiet_left > acc_n) ? quiet_left - acc_n : 0;
    end else begin
      sens = (sens_q8 > 256) ? 256 : sens_q8;
      r_q8 = 1152 - 3 * sens;
      floor_ms = (last_ms > 1) ? last_ms : 1;
      hit = (mean > thr_lvl * thr_lvl) && ((mean << 16) > r_q8 * r_q8 * floor_ms);
      if (hit) quiet_left = cool_len;
    end
    last_ms = mean & 64'h7FFF_FFFF;
    acc_sq = 0;
    acc_n = 0;
    res.transient = hit;
    res.block_mean_square = last_ms[betd_pkg::MEAN_W-1:0];
    res.cooling_down = cooling;
    pending_blocks.push_back(res);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        flag_error("result beat with no block pending");
      end else begin
        want = pending_blocks.pop_front();
        if (out_data.transient !== want.transient)
          flag_error($sformatf("transient got %b want %b", out_data.transient,
                               want.transient));
        if (out_data.block_mean_square !== want.block_mean_square)
          flag_error($sformatf("mean square got %0d want %0d",
                               out_data.block_mean_square, want.block_mean_square));
        if (out_data.cooling_down !== want.cooling_down)
          flag_error($sformatf("cooling_down got %b want %b", out_data.cooling_down,
                               want.cooling_down));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : ready_gen
    int k;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [betd_pkg::SAMPLE_BITS-1:0] s, input logic last);
    int gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{sample: s, last_in_block: last};
    do @(posedge clk); while (!in_ready);
    track_energy(in_data);
    beats_sent++;
  endtask

  // Close any open block, then wait for all results and the block to go idle
  task automatic quiesce;
    if (acc_n != 0) send_beat('0, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input betd_pkg::cfg_idx_t idx,
                           input logic [betd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      betd_pkg::CFG_THRESHOLD: thr_lvl  = longint'(data);
      betd_pkg::CFG_SENS:      sens_q8  = longint'(data[betd_pkg::SENS_W-1:0]);
      betd_pkg::CFG_COOLDOWN:  cool_len = longint'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(input int thr, input int sens, input int cool);
    quiesce();
    cfg_write(betd_pkg::CFG_THRESHOLD, thr[betd_pkg::CFG_DATA_W-1:0]);
    cfg_write(betd_pkg::CFG_SENS, sens[betd_pkg::CFG_DATA_W-1:0]);
    cfg_write(betd_pkg::CFG_COOLDOWN, cool[betd_pkg::CFG_DATA_W-1:0]);
  endtask

  function automatic logic [betd_pkg::SAMPLE_BITS-1:0] pick_sample(input int bits);
    int v;
    int r;
    r = 0;
    if (bits >= betd_pkg::SAMPLE_BITS) begin
      r = $urandom;
    end else if (bits != 0) begin
      v = $urandom_range(0, (1 << bits) - 1);
      r = $urandom_range(0, 1) ? -v : v;
    end
    return r[betd_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Reset values in effect: first loud block is a hit, later ones fall in cooldown
  task automatic test_defaults;
    send_beat(16'h8000, 1'b1);
    send_beat(16'h7FFF, 1'b1);
    send_beat(16'h0000, 1'b1);
  endtask

  task automatic test_extremes;
    set_config(0, 256, 0);
    send_beat(16'h0001, 1'b1);
    send_beat(16'hFFFF, 1'b1);
    send_beat(16'h0000, 1'b1);
    send_beat(16'h7FFF, 1'b1);
    send_beat(16'h8000, 1'b1);
    send_beat(16'h5555, 1'b0);
    send_beat(16'hAAAA, 1'b1);
    set_config(32768, 0, 0);
    send_beat(16'h0010, 1'b1);
    send_beat(16'h8000, 1'b1);
  endtask

  // Sensitivity above one saturates; a threshold whose square exceeds the mean-square range is squared unclamped
  task automatic test_range_limits;
    set_config(20, 511, 0);
    send_beat(16'h0004, 1'b1);
    send_beat(16'h0100, 1'b1);
    set_config(65535, 257, 0);
    send_beat(16'h0001, 1'b1);
    send_beat(16'h8000, 1'b1);
  endtask

  // Cooldown charge: decrement by block size, saturating at zero
  task automatic test_cooldown_charge;
    int k;
    set_config(100, 256, 5);
    send_beat(16'h000A, 1'b1);
    send_beat(16'h8000, 1'b1);
    for (k = 0; k < 8; k++) send_beat(16'h0200, k == 7);
    send_beat(16'h0001, 1'b1);
    set_config(100, 256, 100);
    send_beat(16'h000A, 1'b1);
    send_beat(16'h8000, 1'b1);
    repeat (4)
      for (k = 0; k < 30; k++) send_beat(16'hC000, k == 29);
    send_beat(16'h0001, 1'b1);
  endtask

  // No mark: the sample that fills the block ends it
  task automatic test_full_block;
    int k;
    set_config(1000, 128, 0);
    for (k = 0; k < betd_pkg::BLOCK_MAX; k++)
      send_beat(pick_sample(betd_pkg::SAMPLE_BITS), 1'b0);
    for (k = 0; k < 3; k++) send_beat(pick_sample(12), k == 2);
  endtask

  // Receiver holds off while single-sample blocks keep coming
  task automatic test_backpressure;
    int k;
    set_config(500, 200, 0);
    idle_pct = 0;
    hold_req = 1'b1;
    for (k = 0; k < 24; k++) send_beat(pick_sample($urandom_range(0, 16)), 1'b1);
  endtask

  task automatic test_random(input int n, input int thr, input int sens, input int cool,
                             input int idle);
    int stop_at, len, kind, bits, k;
    logic mark;
    set_config(thr, sens, cool);
    idle_pct = idle;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      bits = $urandom_range(0, 16);
      mark = 1'b1;
      if (kind == 0) begin
        len = betd_pkg::BLOCK_MAX;
        mark = 1'b0;
      end else if (kind == 1) begin
        len = $urandom_range(betd_pkg::BLOCK_MAX + 1, betd_pkg::BLOCK_MAX + 16);
      end else if (kind <= 5) begin
        len = $urandom_range(9, betd_pkg::BLOCK_MAX);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (k = 0; k < len; k++)
        send_beat(pick_sample(bits),
                  (mark && k == len - 1) || ($urandom_range(0, 59) == 0));
    end
  endtask

  initial begin
    thr_lvl = longint'(betd_pkg::THR_RESET);
    sens_q8 = longint'(betd_pkg::SENS_RESET);
    cool_len = longint'(betd_pkg::COOL_RESET);
    acc_sq = 0;
    acc_n = 0;
    last_ms = 0;
    quiet_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_extremes();
    test_range_limits();
    test_cooldown_charge();
    test_full_block();
    test_backpressure();
    test_random(260, 200, 128, 50, 20);
    test_random(260, 0, 0, 0, 30);
    test_random(260, 65535, 511, 65535, 10);
    test_random(260, $urandom_range(0, 4000), $urandom_range(0, 511),
                $urandom_range(0, 300), 25);
    test_random(260, 32768, 256, 1, 15);
    test_random(300, 1000, 200, 120, 0);
    quiesce();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
